[sv/sparse_triangular_solve_core_defines.svh]
// Assertion macros used by the checker of the solver core.
`ifndef SPARSE_TRIANGULAR_SOLVE_CORE_DEFINES_SVH
`define SPARSE_TRIANGULAR_SOLVE_CORE_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent.
`define STS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define STS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

[sv/sts_pkg.sv]
package sts_pkg;

  localparam int ORDER     = 64;
  localparam int IDX_W     = $clog2(ORDER);
  localparam int ENTRIES   = 1024;
  localparam int ENT_AW    = $clog2(ENTRIES);
  localparam int CNT_W     = ENT_AW + 1;
  localparam int ORD_W     = 7;
  localparam int VAL_W     = 32;
  localparam int ACC_W     = 2 * VAL_W;
  localparam int DIV_STEPS = ACC_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

  localparam logic signed [VAL_W-1:0] Q_ONE = 32'sh0001_0000;

  // input word kinds
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ENTRY = 2'd1,
    OP_RHS   = 2'd2,
    OP_SOLVE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    M_LOWER = 2'd0,
    M_UPPER = 2'd1,
    M_UNIT  = 2'd2,
    M_ILU   = 2'd3
  } mode_t;

  // result status codes
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_DIAG = 2'd1;
  localparam logic [1:0] STAT_OVF  = 2'd2;

  // configuration register indexes
  localparam logic CFG_MODE  = 1'b0;
  localparam logic CFG_ORDER = 1'b1;

  // sweep over the rows: diagonal check, lower, upper, result output
  typedef enum logic [1:0] {
    P_CHK = 2'd0,
    P_LO  = 2'd1,
    P_UP  = 2'd2,
    P_OUT = 2'd3
  } pass_t;

  typedef struct packed {
    logic  load;
    logic  start;
    logic  pfx_rd;
    logic  pfx_wr;
    logic  pass_beg;
    logic  row_rd;
    logic  row_ini;
    logic  ent_rd;
    logic  ent_dat;
    logic  ent_mul;
    logic  ent_acc;
    logic  diag_wr;
    logic  div_start;
    logic  div_step;
    logic  wv_wr;
    logic  row_adv;
    logic  out_rd;
    logic  out_ld;
    logic  err_ld;
    pass_t pass;
    logic  unit;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  pfx_last;
    logic  k_lt_hi;
    logic  diag_bad;
    logic  div_done;
    logic  row_last;
    logic  out_free;
  } sts_t;

endpackage

[sv/sts_ctrl.sv]
module sts_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  input  logic [1:0]    in_op,
  output logic          in_tready,
  output sts_pkg::cmd_t cmd,
  input  sts_pkg::sts_t sts
);

  typedef enum logic [15:0] {
    S_IDLE    = 16'h0001,
    S_PFX_RD  = 16'h0002,
    S_PFX_WR  = 16'h0004,
    S_PASS    = 16'h0008,
    S_ROW_RD  = 16'h0010,
    S_ROW_INI = 16'h0020,
    S_ENT_RD  = 16'h0040,
    S_ENT_DAT = 16'h0080,
    S_ENT_WV  = 16'h0100,
    S_ENT_MUL = 16'h0200,
    S_ROW_END = 16'h0400,
    S_DIV     = 16'h0800,
    S_ROW_WR  = 16'h1000,
    S_ERR     = 16'h2000,
    S_OUT_RD  = 16'h4000,
    S_OUT_LD  = 16'h8000
  } state_t;

  state_t         state_r, state_nxt;
  sts_pkg::pass_t pass_r, pass_nxt;
  logic           unit_r, unit_nxt;

  assign in_tready = (state_r == S_IDLE);

  // sequence the sweeps and issue datapath commands
  always_comb begin
    state_nxt    = state_r;
    pass_nxt     = pass_r;
    unit_nxt     = unit_r;
    cmd          = '0;
    cmd.pass     = pass_r;
    cmd.unit     = unit_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load = 1'b1;
          if (sts_pkg::op_t'(in_op) == sts_pkg::OP_SOLVE) begin
            cmd.start = 1'b1;
            state_nxt = S_PFX_RD;
          end
        end
      end
      S_PFX_RD: begin
        cmd.pfx_rd = 1'b1;
        state_nxt  = S_PFX_WR;
      end
      S_PFX_WR: begin
        cmd.pfx_wr = 1'b1;
        if (sts.pfx_last) begin
          pass_nxt  = (sts.mode == sts_pkg::M_UNIT) ? sts_pkg::P_LO : sts_pkg::P_CHK;
          unit_nxt  = (sts.mode == sts_pkg::M_UNIT) || (sts.mode == sts_pkg::M_ILU);
          state_nxt = S_PASS;
        end else begin
          state_nxt = S_PFX_RD;
        end
      end
      S_PASS: begin
        cmd.pass_beg = 1'b1;
        state_nxt    = (pass_r == sts_pkg::P_OUT) ? S_OUT_RD : S_ROW_RD;
      end
      S_ROW_RD: begin
        cmd.row_rd = 1'b1;
        state_nxt  = S_ROW_INI;
      end
      S_ROW_INI: begin
        cmd.row_ini = 1'b1;
        state_nxt   = S_ENT_RD;
      end
      S_ENT_RD: begin
        if (sts.k_lt_hi) begin
          cmd.ent_rd = 1'b1;
          state_nxt  = S_ENT_DAT;
        end else begin
          state_nxt = S_ROW_END;
        end
      end
      S_ENT_DAT: begin
        cmd.ent_dat = 1'b1;
        state_nxt   = (pass_r == sts_pkg::P_CHK) ? S_ENT_RD : S_ENT_WV;
      end
      S_ENT_WV: begin
        cmd.ent_mul = 1'b1;
        state_nxt   = S_ENT_MUL;
      end
      S_ENT_MUL: begin
        cmd.ent_acc = 1'b1;
        state_nxt   = S_ENT_RD;
      end
      S_ROW_END: begin
        if (pass_r == sts_pkg::P_CHK) begin
          if (sts.diag_bad) begin
            state_nxt = S_ERR;
          end else begin
            cmd.diag_wr = 1'b1;
            cmd.row_adv = 1'b1;
            if (sts.row_last) begin
              pass_nxt  = (sts.mode == sts_pkg::M_UPPER) ? sts_pkg::P_UP : sts_pkg::P_LO;
              state_nxt = S_PASS;
            end else begin
              state_nxt = S_ROW_RD;
            end
          end
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_ROW_WR;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_ROW_WR: begin
        cmd.wv_wr   = 1'b1;
        cmd.row_adv = 1'b1;
        if (sts.row_last) begin
          if (pass_r == sts_pkg::P_LO && sts.mode == sts_pkg::M_ILU) begin
            pass_nxt = sts_pkg::P_UP;
          end else begin
            pass_nxt = sts_pkg::P_OUT;
          end
          state_nxt = S_PASS;
        end else begin
          state_nxt = S_ROW_RD;
        end
      end
      S_ERR: begin
        if (sts.out_free) begin
          cmd.err_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_OUT_RD: begin
        cmd.out_rd = 1'b1;
        state_nxt  = S_OUT_LD;
      end
      S_OUT_LD: begin
        if (sts.out_free) begin
          cmd.out_ld  = 1'b1;
          cmd.row_adv = 1'b1;
          state_nxt   = sts.row_last ? S_IDLE : S_OUT_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pass_r  <= sts_pkg::P_CHK;
      unit_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pass_r  <= pass_nxt;
      unit_r  <= unit_nxt;
    end
  end

endmodule

[sv/sts_dpath.sv]
module sts_dpath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  sts_pkg::cmd_t                    cmd,
  input  logic [1:0]                       in_op,
  input  logic [sts_pkg::IDX_W-1:0]        in_row,
  input  logic [sts_pkg::IDX_W-1:0]        in_col,
  input  logic signed [sts_pkg::VAL_W-1:0] in_val,
  input  logic                             cfg_we,
  input  logic                             cfg_addr,
  input  logic [sts_pkg::ORD_W-1:0]        cfg_wdata,
  output sts_pkg::sts_t                    sts,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [39:0]                      out_tdata,
  output logic [1:0]                       out_tuser,
  output logic                             out_tlast
);

  localparam int IW = sts_pkg::IDX_W;
  localparam int CW = sts_pkg::CNT_W;
  localparam int VW = sts_pkg::VAL_W;
  localparam int AW = sts_pkg::ACC_W;

  // configuration
  sts_pkg::mode_t         mode_r;
  logic [sts_pkg::ORD_W-1:0] order_r;

  // load-side control state
  logic [CW-1:0]             count_r;
  logic                      ovf_r;
  logic [sts_pkg::ORDER-1:0] lp_vld_r;
  logic                      out_valid_r;

  // memories
  logic [CW-1:0]           lp_mem [sts_pkg::ORDER];
  logic [CW-1:0]           rs_mem [sts_pkg::ORDER];
  logic [IW+VW-1:0]        ent_mem [sts_pkg::ENTRIES];
  logic signed [VW-1:0]    wv_mem [sts_pkg::ORDER];
  logic signed [VW-1:0]    dg_mem [sts_pkg::ORDER];

  // registered read data
  logic [CW-1:0]        lp_q_r, rs_hi_q_r, rs_lo_q_r;
  logic                 lp_vld_q_r, lo_zero_r;
  logic [IW-1:0]        ent_col_q_r;
  logic signed [VW-1:0] ent_val_q_r, wva_q_r, wvb_q_r, dg_q_r;

  // sweep datapath
  logic [sts_pkg::ORD_W-1:0] n_r;
  logic [IW-1:0]        idx_r;
  logic [CW-1:0]        pmax_r, k_r, hi_r;
  logic signed [AW-1:0] acc_r, prod_r;
  logic                 use_r, found_r;
  logic signed [VW-1:0] d_r;

  // divider
  logic [VW-1:0]                rem_r, md_r;
  logic [AW-1:0]                dq_r;
  logic                         neg_r;
  logic [sts_pkg::DCNT_W-1:0]   dcnt_r;

  logic                 ld_entry, ld_rhs, ld_clear, full;
  logic [CW-1:0]        count_inc, lp_v, pmax_new;
  logic [VW:0]          div_t, div_md;
  logic                 div_ge;
  logic signed [VW-1:0] qres;
  logic [sts_pkg::ORD_W-1:0] n_new;
  logic                 use_nxt;
  logic                 wv_we;
  logic [IW-1:0]        wv_wa;
  logic signed [VW-1:0] wv_wd;

  assign ld_clear  = cmd.load && (sts_pkg::op_t'(in_op) == sts_pkg::OP_CLEAR);
  assign ld_entry  = cmd.load && (sts_pkg::op_t'(in_op) == sts_pkg::OP_ENTRY);
  assign ld_rhs    = cmd.load && (sts_pkg::op_t'(in_op) == sts_pkg::OP_RHS);
  assign full      = (count_r == CW'(sts_pkg::ENTRIES));
  assign count_inc = count_r + CW'(1);

  // clamp the order to 1..ORDER
  always_comb begin
    if (order_r == '0) begin
      n_new = sts_pkg::ORD_W'(1);
    end else if (order_r > sts_pkg::ORD_W'(sts_pkg::ORDER)) begin
      n_new = sts_pkg::ORD_W'(sts_pkg::ORDER);
    end else begin
      n_new = order_r;
    end
  end

  // running maximum of row end positions
  assign lp_v     = lp_vld_q_r ? lp_q_r : '0;
  assign pmax_new = (lp_v > pmax_r) ? lp_v : pmax_r;

  // term selection by column
  always_comb begin
    if (cmd.pass == sts_pkg::P_UP) begin
      use_nxt = (ent_col_q_r > idx_r) && ({1'b0, ent_col_q_r} < n_r);
    end else begin
      use_nxt = (ent_col_q_r < idx_r);
    end
  end

  // one restoring divide step
  assign div_md = {1'b0, md_r};
  assign div_t  = {rem_r, dq_r[AW-1]};
  assign div_ge = (div_t >= div_md);

  // sign and saturate the quotient; a zero divisor gives zero
  always_comb begin
    if (md_r == '0) begin
      qres = '0;
    end else if (neg_r) begin
      if (dq_r[AW-1:VW-1] != '0) begin
        qres = {1'b1, {(VW-1){1'b0}}};
      end else begin
        qres = -$signed(dq_r[VW-1:0]);
      end
    end else begin
      if (dq_r[AW-1:VW-1] != '0) begin
        qres = {1'b0, {(VW-1){1'b1}}};
      end else begin
        qres = $signed(dq_r[VW-1:0]);
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= sts_pkg::M_LOWER;
      order_r <= sts_pkg::ORD_W'(sts_pkg::ORDER);
    end else if (cfg_we) begin
      case (cfg_addr)
        sts_pkg::CFG_MODE:  mode_r  <= sts_pkg::mode_t'(cfg_wdata[1:0]);
        sts_pkg::CFG_ORDER: order_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // store fill state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ovf_r       <= 1'b0;
      lp_vld_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ld_clear) begin
        count_r  <= '0;
        ovf_r    <= 1'b0;
        lp_vld_r <= '0;
      end else if (ld_entry) begin
        if (full) begin
          ovf_r <= 1'b1;
        end else begin
          count_r          <= count_inc;
          lp_vld_r[in_row] <= 1'b1;
        end
      end
      if (cmd.out_ld || cmd.err_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // row end position per row
  always_ff @(posedge clk) begin
    if (ld_entry && !full) begin
      lp_mem[in_row] <= count_inc;
    end
    if (cmd.pfx_rd) begin
      lp_q_r     <= lp_mem[idx_r];
      lp_vld_q_r <= lp_vld_r[idx_r];
    end
  end

  // row end after prefix maximum; row start is the previous row's end
  always_ff @(posedge clk) begin
    if (cmd.pfx_wr) begin
      rs_mem[idx_r] <= pmax_new;
    end
    if (cmd.row_rd) begin
      rs_hi_q_r <= rs_mem[idx_r];
      rs_lo_q_r <= rs_mem[idx_r - IW'(1)];
      lo_zero_r <= (idx_r == '0);
    end
  end

  // entry store
  always_ff @(posedge clk) begin
    if (ld_entry && !full) begin
      ent_mem[count_r[sts_pkg::ENT_AW-1:0]] <= {in_val, in_col};
    end
    if (cmd.ent_rd) begin
      {ent_val_q_r, ent_col_q_r} <= ent_mem[k_r[sts_pkg::ENT_AW-1:0]];
    end
  end

  // work vector: rhs load or solved row
  assign wv_we = ld_rhs || cmd.wv_wr;
  assign wv_wa = cmd.wv_wr ? idx_r : in_row;
  assign wv_wd = cmd.wv_wr ? qres : in_val;

  always_ff @(posedge clk) begin
    if (wv_we) begin
      wv_mem[wv_wa] <= wv_wd;
    end
    if (cmd.row_rd || cmd.out_rd) begin
      wva_q_r <= wv_mem[idx_r];
    end
    if (cmd.ent_dat) begin
      wvb_q_r <= wv_mem[ent_col_q_r];
    end
  end

  // diagonal per row, kept from the check sweep
  always_ff @(posedge clk) begin
    if (cmd.diag_wr) begin
      dg_mem[idx_r] <= d_r;
    end
    if (cmd.row_rd) begin
      dg_q_r <= dg_mem[idx_r];
    end
  end

  // sweep and divider registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      n_r    <= n_new;
      idx_r  <= '0;
      pmax_r <= '0;
    end
    if (cmd.pfx_wr) begin
      pmax_r <= pmax_new;
      idx_r  <= idx_r + IW'(1);
    end
    if (cmd.pass_beg) begin
      idx_r <= (cmd.pass == sts_pkg::P_UP) ? IW'(n_r - sts_pkg::ORD_W'(1)) : '0;
    end
    if (cmd.row_adv) begin
      idx_r <= (cmd.pass == sts_pkg::P_UP) ? idx_r - IW'(1) : idx_r + IW'(1);
    end
    if (cmd.row_ini) begin
      k_r     <= lo_zero_r ? '0 : rs_lo_q_r;
      hi_r    <= rs_hi_q_r;
      acc_r   <= {wva_q_r, {VW{1'b0}}};
      found_r <= 1'b0;
      d_r     <= (cmd.pass == sts_pkg::P_LO && cmd.unit) ? sts_pkg::Q_ONE : dg_q_r;
    end
    if (cmd.ent_rd) begin
      k_r <= k_r + CW'(1);
    end
    // first entry on the diagonal wins
    if (cmd.ent_dat && cmd.pass == sts_pkg::P_CHK && !found_r && ent_col_q_r == idx_r) begin
      found_r <= 1'b1;
      d_r     <= ent_val_q_r;
    end
    if (cmd.ent_mul) begin
      prod_r <= ent_val_q_r * wvb_q_r;
      use_r  <= use_nxt;
    end
    if (cmd.ent_acc && use_r) begin
      acc_r <= acc_r - prod_r;
    end
    if (cmd.div_start) begin
      dq_r   <= acc_r[AW-1] ? AW'(-acc_r) : AW'(acc_r);
      md_r   <= d_r[VW-1] ? VW'(-d_r) : VW'(d_r);
      neg_r  <= acc_r[AW-1] ^ d_r[VW-1];
      rem_r  <= '0;
      dcnt_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r  <= div_ge ? VW'(div_t - div_md) : div_t[VW-1:0];
      dq_r   <= {dq_r[AW-2:0], div_ge};
      dcnt_r <= dcnt_r + sts_pkg::DCNT_W'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_tdata <= {2'b00, wva_q_r, idx_r};
      out_tuser <= ovf_r ? sts_pkg::STAT_OVF : sts_pkg::STAT_OK;
      out_tlast <= sts.row_last;
    end else if (cmd.err_ld) begin
      out_tdata <= '0;
      out_tuser <= sts_pkg::STAT_DIAG;
      out_tlast <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;

  // status toward the controller
  always_comb begin
    sts.mode     = mode_r;
    sts.pfx_last = (idx_r == IW'(sts_pkg::ORDER - 1));
    sts.k_lt_hi  = (k_r < hi_r);
    sts.diag_bad = !found_r || (d_r == '0);
    sts.div_done = (dcnt_r == sts_pkg::DCNT_W'(sts_pkg::DIV_STEPS));
    sts.row_last = (cmd.pass == sts_pkg::P_UP) ? (idx_r == '0)
                                               : ({1'b0, idx_r} == n_r - sts_pkg::ORD_W'(1));
    sts.out_free = !out_valid_r || out_tready;
  end

endmodule

[sv/sparse_triangular_solve_core.sv]
// Sparse triangular solver over a compressed-row entry store (1024 entries,
// order up to 64, Q16.16 values). Clear, entry and rhs words are taken one per
// cycle while no solve is running. A solve word holds the input for the whole
// solve: a prefix sweep builds the row ranges, then (modes lower, upper, ilu) a
// diagonal check sweep finds each row's diagonal, and each solve sweep reads each
// row's entries and runs the 64-step restoring divider once per row, with all
// entry reads through the single entry-store read port. The n results are read
// and loaded into the result register one at a time, each waiting until the
// sink is free. A missing or zero diagonal gives a single result with status 1.
// Reset needs no clearing sweep; the store is empty after reset or a clear word.
module sparse_triangular_solve_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // row_index[5:0], col_index[11:6], value[43:12]
  input  logic [1:0]  in_tuser,   // opcode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // sol_index[5:0], sol_value[37:6]
  output logic [1:0]  out_tuser,  // status[1:0]
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [6:0]  cfg_wdata
);

  sts_pkg::cmd_t cmd;
  sts_pkg::sts_t sts;

  sts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_op     (in_tuser),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  sts_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_op      (in_tuser),
    .in_row     (in_tdata[5:0]),
    .in_col     (in_tdata[11:6]),
    .in_val     (in_tdata[43:12]),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

[sv/sts_chk.sv]
`include "sparse_triangular_solve_core_defines.svh"

module sts_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  // a pending result stays offered
  `STS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result dropped while stalled")

  // a diagonal error is a single zero word closing the solve
  `STS_ASSERT_NOW(a_err_word, out_tvalid && out_tuser == sts_pkg::STAT_DIAG, out_tlast && out_tdata == '0, "malformed diagonal error word")

  // a solve word blocks the input in the next cycle
  `STS_ASSERT_NEXT(a_solve_busy, in_tvalid && in_tready && in_tuser == sts_pkg::OP_SOLVE, !in_tready, "input taken during solve")

endmodule

bind sparse_triangular_solve_core sts_chk u_sts_chk (.*);
